/* rtl/core/lcd_mode_timing_sequencer_unit_defines.svh */
// ---------------------------------------------------------------------------
// LCD mode timing sequencer: assertion macros
// Shared macros for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_SEQUENCER_UNIT_DEFINES_SVH
`define LCD_MODE_TIMING_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define LMTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lmts: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define LMTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lmts: next-cycle check failed");

`endif

/* rtl/core/lmts_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode timing sequencer package
// Mode codes, phase lengths, register indexes and shared structs.
// ---------------------------------------------------------------------------
package lmts_pkg;

	// Mode codes as seen on the lcd_mode output
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_XFER   = 2'd3;

	// Phase lengths in machine cycles
	localparam logic [9:0] LEN_OAM    = 10'd80;
	localparam logic [9:0] LEN_XFER   = 10'd172;
	localparam logic [9:0] LEN_HBLANK = 10'd204;
	localparam logic [9:0] LEN_VLINE  = 10'd456;

	// Line boundaries
	localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
	localparam logic [7:0] LINES_PER_FRAME   = 8'd154;

	// Configuration register indexes
	localparam logic [1:0] CFG_LINE_COMPARE = 2'd0;
	localparam logic [1:0] CFG_HBLANK_IRQ   = 2'd1;
	localparam logic [1:0] CFG_COINC_IRQ    = 2'd2;

	// Internal mode state, one-hot
	typedef enum logic [3:0] {
		ST_HBLANK = 4'b0001,
		ST_VBLANK = 4'b0010,
		ST_OAM    = 4'b0100,
		ST_XFER   = 4'b1000
	} mode_state_t;

	// Configuration registers
	typedef struct packed {
		logic [7:0] line_compare;
		logic       hblank_irq_enable;
		logic       coincidence_irq_enable;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic [1:0] lcd_mode;
		logic [7:0] current_line;
		logic       coincidence_flag;
		logic       status_irq;
		logic       vblank_irq;
		logic       render_line;
		logic [7:0] render_line_number;
		logic       frame_done;
	} res_t;

	// One-hot state to output mode code
	function automatic logic [1:0] mode_code(input mode_state_t st);
		logic [1:0] code;
		unique case (st)
			ST_HBLANK: code = MODE_HBLANK;
			ST_VBLANK: code = MODE_VBLANK;
			ST_OAM:    code = MODE_OAM;
			ST_XFER:   code = MODE_XFER;
			default:   code = MODE_OAM;
		endcase
		return code;
	endfunction

endpackage

/* rtl/core/lmts_step.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode timing sequencer: step logic
// Holds dot counter, mode, line and coincidence state; computes one result
// word per advance from the registered elapsed-cycle count.
// ---------------------------------------------------------------------------
module lmts_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [5:0]    elapsed_s1,
	input  lmts_pkg::cfg_t cfg,
	output lmts_pkg::res_t res
);
	import lmts_pkg::*;

	logic [9:0]  dot_q;
	mode_state_t st_q;
	logic [7:0]  line_q;
	logic        coinc_q;

	logic [9:0]  dot_sum;
	logic [9:0]  dot_d;
	mode_state_t st_d;
	logic [7:0]  line_d;
	logic [7:0]  line_inc;
	logic        coinc_d;
	logic        line_eq;
	logic        stat;
	logic        vbl;
	logic        rend;
	logic [7:0]  rend_no;
	logic        done;

	assign dot_sum  = dot_q + {4'd0, elapsed_s1};
	assign line_inc = line_q + 8'd1;
	assign line_eq  = (line_q == cfg.line_compare);

	// Next state: at most one phase change per word
	always_comb begin
		dot_d   = dot_sum;
		st_d    = st_q;
		line_d  = line_q;
		coinc_d = coinc_q;
		stat    = 1'b0;
		vbl     = 1'b0;
		rend    = 1'b0;
		rend_no = 8'd0;
		done    = 1'b0;
		unique case (st_q)
			ST_OAM: begin
				if (dot_sum >= LEN_OAM) begin
					dot_d = dot_sum - LEN_OAM;
					st_d  = ST_XFER;
				end
			end
			ST_XFER: begin
				// transfer end: latch coincidence, maybe request status irq
				if (dot_sum >= LEN_XFER) begin
					dot_d   = dot_sum - LEN_XFER;
					st_d    = ST_HBLANK;
					coinc_d = line_eq;
					stat    = cfg.hblank_irq_enable | (cfg.coincidence_irq_enable & line_eq);
				end
			end
			ST_HBLANK: begin
				// line finished: render strobe, next line or vblank
				if (dot_sum >= LEN_HBLANK) begin
					dot_d   = dot_sum - LEN_HBLANK;
					rend    = 1'b1;
					rend_no = line_q;
					line_d  = line_inc;
					if (line_inc == FIRST_VBLANK_LINE) begin
						st_d = ST_VBLANK;
						vbl  = 1'b1;
					end else begin
						st_d = ST_OAM;
					end
				end
			end
			ST_VBLANK: begin
				if (dot_sum >= LEN_VLINE) begin
					dot_d  = dot_sum - LEN_VLINE;
					line_d = line_inc;
					if (line_inc == LINES_PER_FRAME) begin
						done   = 1'b1;
						line_d = 8'd0;
						st_d   = ST_OAM;
					end
				end
			end
			default: begin
				st_d = ST_OAM;
			end
		endcase
	end

	// State registers, updated once per advanced word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= 10'd0;
			st_q    <= ST_OAM;
			line_q  <= 8'd0;
			coinc_q <= 1'b0;
		end else if (advance) begin
			dot_q   <= dot_d;
			st_q    <= st_d;
			line_q  <= line_d;
			coinc_q <= coinc_d;
		end
	end

	// Result word for the output register
	always_comb begin
		res.lcd_mode           = mode_code(st_d);
		res.current_line       = line_d;
		res.coincidence_flag   = coinc_d;
		res.status_irq         = stat;
		res.vblank_irq         = vbl;
		res.render_line        = rend;
		res.render_line_number = rend_no;
		res.frame_done         = done;
	end

endmodule

/* rtl/core/lmts_out_reg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode timing sequencer: output register
// Holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
module lmts_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  lmts_pkg::res_t res,
	input  logic           out_stall,
	output logic           out_valid,
	output lmts_pkg::res_t res_q
);
	import lmts_pkg::*;

	logic valid_q;

	// Valid flag: set on load, cleared when taken with nothing new
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule

/* rtl/core/lcd_mode_timing_sequencer_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode timing sequencer
// Steps LCD modes and scanlines from elapsed machine-cycle counts.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / elapsed_cycles) takes one word per
//   cycle while in_stall is low; each word carries the machine cycles
//   elapsed since the last one. Output channel (out_valid / out_stall /
//   result fields) gives exactly one result word per input word, in order.
//   Path: an accepted word is held in the input register; its result word is
//   loaded into the output register once that is free or being emptied.
//   Throughput: one word per cycle while the receiver does not stall; the
//   dot counter add, one compare and one subtract per phase close the state loop.
//   Config port (cfg_write / cfg_index / cfg_data) writes line_compare (0),
//   hblank irq enable (1) and coincidence irq enable (2); other indexes are
//   ignored. Write only while no word is in flight.
//   Reset: mode is OAM search, dot counter, line and coincidence are zero,
//   all config registers are zero, no word is held.
//   When the receiver stalls, the output word holds; the next word waits in
//   the input register and in_stall rises only once both are full.
// ---------------------------------------------------------------------------
module lcd_mode_timing_sequencer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [5:0] elapsed_cycles,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] lcd_mode,
	output logic [7:0] current_line,
	output logic       coincidence_flag,
	output logic       status_irq,
	output logic       vblank_irq,
	output logic       render_line,
	output logic [7:0] render_line_number,
	output logic       frame_done
);
	import lmts_pkg::*;

	`include "lcd_mode_timing_sequencer_unit_defines.svh"

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [5:0] elapsed_s1;
	logic       advance;
	logic       in_take;
	res_t       res;
	res_t       res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_LINE_COMPARE: cfg_q.line_compare           <= cfg_data;
				CFG_HBLANK_IRQ:   cfg_q.hblank_irq_enable      <= cfg_data[0];
				CFG_COINC_IRQ:    cfg_q.coincidence_irq_enable <= cfg_data[0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Handshake: the step runs when the input register is full and the
	// output register is free or being emptied
	assign advance  = valid_s1 & (~out_valid | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			elapsed_s1 <= elapsed_cycles;
		end
	end

	lmts_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.elapsed_s1(elapsed_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	lmts_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.res_q    (res_q)
	);

	assign lcd_mode           = res_q.lcd_mode;
	assign current_line       = res_q.current_line;
	assign coincidence_flag   = res_q.coincidence_flag;
	assign status_irq         = res_q.status_irq;
	assign vblank_irq         = res_q.vblank_irq;
	assign render_line        = res_q.render_line;
	assign render_line_number = res_q.render_line_number;
	assign frame_done         = res_q.frame_done;

	// Checks
	`LMTS_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, in_stall, valid_s1 && out_valid && out_stall)
	`LMTS_ASSERT_IMP(a_frame_done_restarts, clk, arst_n, out_valid && frame_done, current_line == 8'd0 && lcd_mode == MODE_OAM)
	`LMTS_ASSERT_IMP(a_vblank_after_render, clk, arst_n, out_valid && vblank_irq, render_line && current_line == FIRST_VBLANK_LINE && lcd_mode == MODE_VBLANK)
	`LMTS_ASSERT_IMP(a_render_next_line, clk, arst_n, out_valid && render_line, current_line == render_line_number + 8'd1)
	`LMTS_ASSERT_NXT(a_advance_loads_out, clk, arst_n, advance, out_valid)

endmodule

/* test/lcd_timing_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode timing checker
// Watches the config port and both word channels of the LCD mode timing
// sequencer. It keeps its own copy of the dot counter, mode, line and
// coincidence state, predicts one result word per accepted input word and
// compares every accepted output word, field by field, with the oldest
// prediction.
// ---------------------------------------------------------------------------
module lcd_timing_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [5:0] elapsed_cycles,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] lcd_mode,
	input  logic [7:0] current_line,
	input  logic       coincidence_flag,
	input  logic       status_irq,
	input  logic       vblank_irq,
	input  logic       render_line,
	input  logic [7:0] render_line_number,
	input  logic       frame_done,
	output int         fail_count,
	output int         words_in_flight
);
	import lmts_pkg::*;

	// Shadow config
	logic [7:0] cmp_line;
	logic       hblank_irq_on;
	logic       coinc_irq_on;

	// Shadow timing state
	logic [9:0] dots;
	logic [1:0] mode;
	logic [7:0] line;
	logic       coinc;

	res_t expected_words [$];
	int   n_bad;

	assign fail_count = n_bad;

	// Advance the timing state by one word of elapsed cycles
	task automatic advance_timing(input logic [5:0] cyc, output res_t w);
		logic match;
		w = '0;
		dots = dots + 10'(cyc);
		case (mode)
			MODE_OAM: begin
				if (dots >= LEN_OAM) begin
					dots = dots - LEN_OAM;
					mode = MODE_XFER;
				end
			end
			MODE_XFER: begin
				if (dots >= LEN_XFER) begin
					match = (line == cmp_line);
					dots = dots - LEN_XFER;
					mode = MODE_HBLANK;
					w.status_irq = hblank_irq_on | (coinc_irq_on & match);
					coinc = match;
				end
			end
			MODE_HBLANK: begin
				if (dots >= LEN_HBLANK) begin
					dots = dots - LEN_HBLANK;
					w.render_line = 1'b1;
					w.render_line_number = line;
					line = line + 8'd1;
					if (line == FIRST_VBLANK_LINE) begin
						mode = MODE_VBLANK;
						w.vblank_irq = 1'b1;
					end else begin
						mode = MODE_OAM;
					end
				end
			end
			default: begin
				// vblank: whole lines, wrap to line 0 at frame end
				if (dots >= LEN_VLINE) begin
					dots = dots - LEN_VLINE;
					line = line + 8'd1;
					if (line == LINES_PER_FRAME) begin
						w.frame_done = 1'b1;
						line = 8'd0;
						mode = MODE_OAM;
					end
				end
			end
		endcase
		w.lcd_mode = mode;
		w.current_line = line;
		w.coincidence_flag = coinc;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] got_val, inout logic bad);
		if (got_val !== exp_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
			bad = 1'b1;
		end
	endtask

	// Config shadow, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t fresh;
		logic bad;
		if (!arst_n) begin
			cmp_line = 8'd0;
			hblank_irq_on = 1'b0;
			coinc_irq_on = 1'b0;
			dots = 10'd0;
			mode = MODE_OAM;
			line = 8'd0;
			coinc = 1'b0;
			expected_words.delete();
			n_bad = 0;
			words_in_flight <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_LINE_COMPARE: cmp_line = cfg_data;
					CFG_HBLANK_IRQ:   hblank_irq_on = cfg_data[0];
					CFG_COINC_IRQ:    coinc_irq_on = cfg_data[0];
					default: ;
				endcase
			end
			// outputs first: a word taken now predates any input taken now
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, got mode=%0d line=%0d", $time,
						lcd_mode, current_line);
					n_bad++;
				end else begin
					want = expected_words.pop_front();
					bad = 1'b0;
					check_field("lcd_mode", 8'(want.lcd_mode), 8'(lcd_mode), bad);
					check_field("current_line", want.current_line, current_line, bad);
					check_field("coincidence_flag", 8'(want.coincidence_flag),
						8'(coincidence_flag), bad);
					check_field("status_irq", 8'(want.status_irq), 8'(status_irq), bad);
					check_field("vblank_irq", 8'(want.vblank_irq), 8'(vblank_irq), bad);
					check_field("render_line", 8'(want.render_line), 8'(render_line), bad);
					check_field("render_line_number", want.render_line_number,
						render_line_number, bad);
					check_field("frame_done", 8'(want.frame_done), 8'(frame_done), bad);
					if (bad)
						n_bad++;
				end
			end
			if (in_valid && !in_stall) begin
				advance_timing(elapsed_cycles, fresh);
				expected_words.push_back(fresh);
			end
			words_in_flight <= expected_words.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode timing sequencer testbench
// Drives elapsed-cycle words into the sequencer through several idle and
// stall mixes and config settings, starting with short hand-picked runs that
// land exactly on phase ends, then longer runs biased toward large counts so
// that many scanlines pass. The checker beside the block predicts and
// compares; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
	import lmts_pkg::*;

	localparam int PHASE_WORDS = 195;
	localparam int QUIET_LIMIT = 5000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = CFG_LINE_COMPARE;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [5:0] elapsed_cycles = 6'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] lcd_mode;
	logic [7:0] current_line;
	logic       coincidence_flag;
	logic       status_irq;
	logic       vblank_irq;
	logic       render_line;
	logic [7:0] render_line_number;
	logic       frame_done;

	int fail_count;
	int words_in_flight;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	// Hits OAM and transfer ends exactly, then an hblank end on line 0
	logic [5:0] opening [18] = '{6'd0, 6'd40, 6'd40, 6'd63, 6'd63, 6'd46,
		6'd63, 6'd63, 6'd63, 6'd15, 6'd63, 6'd17, 6'd63, 6'd63, 6'd63, 6'd1,
		6'd2, 6'd62};

	lcd_mode_timing_sequencer_unit i_dut (.*);

	lcd_timing_checker i_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// No-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Offer one word, with random idle cycles ahead of it
	task automatic push_elapsed(input logic [5:0] cyc);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed_cycles <= cyc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// All three registers, plus an ignored write to the unused index;
	// the enables carry junk in their upper data bits
	task automatic load_settings(input logic [7:0] cmp, input logic hb_on,
			input logic co_on);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_LINE_COMPARE;
		cfg_data <= cmp;
		@(posedge clk);
		cfg_index <= CFG_HBLANK_IRQ;
		cfg_data <= {7'($urandom), hb_on};
		@(posedge clk);
		cfg_index <= CFG_COINC_IRQ;
		cfg_data <= {7'($urandom), co_on};
		@(posedge clk);
		cfg_index <= 2'd3;
		cfg_data <= 8'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Sender holds off until every predicted word has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
	endtask

	// Mostly large counts so many lines pass in the run; some full range, some tiny
	function automatic logic [5:0] pick_elapsed();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return 6'($urandom_range(63, 52));
		else if (r < 95)
			return 6'($urandom_range(63, 0));
		else
			return 6'($urandom_range(2, 0));
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening: coincidence on line 0, both irq sources on
		load_settings(8'd0, 1'b1, 1'b1);
		foreach (opening[k])
			push_elapsed(opening[k]);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					load_settings(8'd255, 1'b0, 1'b0);
				end
				1: begin
					idle_pct = 52;
					stall_pct = 0;
					load_settings(8'($urandom_range(143, 1)), 1'b0, 1'b1);
				end
				2: begin
					idle_pct = 0;
					stall_pct = 52;
					load_settings(8'd143, 1'b1, 1'b0);
				end
				default: begin
					idle_pct = 25;
					stall_pct = 25;
					load_settings(8'($urandom_range(255, 0)), 1'b1, 1'b1);
				end
			endcase
			repeat (PHASE_WORDS)
				push_elapsed(pick_elapsed());
			drain_results();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* lcd_mode_timing_sequencer_unit.f */
+incdir+rtl/core
rtl/core/lmts_pkg.sv
rtl/core/lmts_step.sv
rtl/core/lmts_out_reg.sv
rtl/core/lcd_mode_timing_sequencer_unit.sv
test/lcd_timing_checker.sv
test/testbench.sv
